FILE: hw/rtl/rsa_key_recovery_common_factor_unit_defines.svh
// assertion macros used by the rtl unit
`ifndef RSA_KEY_RECOVERY_COMMON_FACTOR_UNIT_DEFINES_SVH
`define RSA_KEY_RECOVERY_COMMON_FACTOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RKR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("rkr assertion failed");
`define RKR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rkr assertion failed");
`else
`define RKR_ASSERT(lbl, clk, rst_n, prop)
`define RKR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/rkr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkr_pkg
// sequencer states and status codes of the common factor key recovery unit
// ----------------------------------------------------------------------------
package rkr_pkg;

	typedef enum logic [9:0] {
		S_IDLE    = 10'b00_0000_0001,
		S_GCD_CHK = 10'b00_0000_0010,
		S_GCD_DIV = 10'b00_0000_0100,
		S_QDIV    = 10'b00_0000_1000,
		S_PHI_MUL = 10'b00_0001_0000,
		S_EXT_CHK = 10'b00_0010_0000,
		S_EXT_DIV = 10'b00_0100_0000,
		S_EXT_MUL = 10'b00_1000_0000,
		S_FIN     = 10'b01_0000_0000,
		S_DONE    = 10'b10_0000_0000
	} state_t;

	typedef logic [1:0] status_t;

	localparam status_t ST_FOUND     = 2'd0;
	localparam status_t ST_NO_FACTOR = 2'd1;
	localparam status_t ST_NOT_INV   = 2'd2;

endpackage

FILE: hw/rtl/rsa_key_recovery_common_factor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_key_recovery_common_factor_unit
// recovers p, q and d from a modulus, an exponent and a block sharing a factor
// ----------------------------------------------------------------------------
// usage:
//   input channel  in_valid/in_ready carries modulus, public_exponent and
//   known_block; output channel out_valid/out_ready carries status, factor_p,
//   factor_q and private_exponent. one result beat per input beat.
//   in_ready is high only while the unit is idle; one item is worked at a time.
// datapath:
//   one restoring divider (one quotient bit per cycle) and one shift-add
//   multiplier are run by the sequencer. gcd takes one divide per euclid
//   step, the inverse one divide and one multiply per step, plus one
//   divide for q and one multiply for phi.
// reset:
//   arst_n clears the sequencer to idle; no result is pending after reset.
// stall:
//   the result is held in output registers until out_ready takes the beat;
//   no new item is accepted before that.
// ----------------------------------------------------------------------------
`include "rsa_key_recovery_common_factor_unit_defines.svh"

module rsa_key_recovery_common_factor_unit
	import rkr_pkg::*;
#(
	parameter int DATA_WIDTH = 63
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_WIDTH-1:0] modulus,
	input  logic [DATA_WIDTH-1:0] public_exponent,
	input  logic [DATA_WIDTH-1:0] known_block,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [DATA_WIDTH-1:0] factor_p,
	output logic [DATA_WIDTH-1:0] factor_q,
	output logic [DATA_WIDTH-1:0] private_exponent
);

	localparam int W  = DATA_WIDTH;
	localparam int MW = DATA_WIDTH + 2;
	localparam int CW = $clog2(DATA_WIDTH);
	localparam logic [CW-1:0] CNT_LAST = CW'(DATA_WIDTH - 1);

	state_t        state_q;
	logic [CW-1:0] cnt_q;

	logic [W-1:0]  n_q, e_q, a_q, b_q, p_q, q_q, phi_q, r_q, nr_q, d_q;
	logic [MW-1:0] t_q, nt_q;
	status_t       status_q;

	// shared restoring divider
	logic [W-1:0]  div_rem_q, div_quo_q, div_den_q;
	logic [W:0]    div_sh;
	logic          div_ge;
	logic [W-1:0]  div_rem_nx, div_quo_nx;

	// shared shift-add multiplier, two's complement mod 2^MW
	logic [MW-1:0] mul_acc_q, mul_mcand_q;
	logic [W-1:0]  mul_mplier_q;
	logic [MW-1:0] mul_acc_nx;

	logic          last;
	logic [MW-1:0] phi_ext;

	assign div_sh     = {div_rem_q, div_quo_q[W-1]};
	assign div_ge     = div_sh >= {1'b0, div_den_q};
	assign div_rem_nx = div_ge ? W'(div_sh - {1'b0, div_den_q}) : div_sh[W-1:0];
	assign div_quo_nx = {div_quo_q[W-2:0], div_ge};
	assign mul_acc_nx = mul_acc_q + (mul_mplier_q[0] ? mul_mcand_q : '0);
	assign last       = cnt_q == CNT_LAST;
	assign phi_ext    = {2'b00, phi_q};

	assign in_ready         = state_q == S_IDLE;
	assign out_valid        = state_q == S_DONE;
	assign status           = status_q;
	assign factor_p         = p_q;
	assign factor_q         = q_q;
	assign private_exponent = d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_GCD_CHK;
				end
				S_GCD_CHK: begin
					cnt_q <= '0;
					if (b_q != '0) state_q <= S_GCD_DIV;
					else if (n_q == '0 || a_q <= W'(1) || a_q == n_q) state_q <= S_DONE;
					else state_q <= S_QDIV;
				end
				S_GCD_DIV: begin
					cnt_q <= last ? '0 : cnt_q + CW'(1);
					if (last) state_q <= S_GCD_CHK;
				end
				S_QDIV: begin
					cnt_q <= last ? '0 : cnt_q + CW'(1);
					if (last) state_q <= S_PHI_MUL;
				end
				S_PHI_MUL: begin
					cnt_q <= last ? '0 : cnt_q + CW'(1);
					if (last) state_q <= S_EXT_CHK;
				end
				S_EXT_CHK: begin
					cnt_q <= '0;
					if (nr_q != '0) state_q <= S_EXT_DIV;
					else if (r_q > W'(1)) state_q <= S_DONE;
					else state_q <= S_FIN;
				end
				S_EXT_DIV: begin
					cnt_q <= last ? '0 : cnt_q + CW'(1);
					if (last) state_q <= S_EXT_MUL;
				end
				S_EXT_MUL: begin
					cnt_q <= last ? '0 : cnt_q + CW'(1);
					if (last) state_q <= S_EXT_CHK;
				end
				S_FIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					n_q <= modulus;
					e_q <= public_exponent;
					a_q <= known_block;
					b_q <= modulus;
				end
			end
			S_GCD_CHK: begin
				div_rem_q <= '0;
				if (b_q != '0) begin
					div_quo_q <= a_q;
					div_den_q <= b_q;
				end else begin
					p_q       <= a_q;
					div_quo_q <= n_q;
					div_den_q <= a_q;
					if (n_q == '0 || a_q <= W'(1) || a_q == n_q) begin
						status_q <= ST_NO_FACTOR;
						q_q      <= '0;
						d_q      <= '0;
					end
				end
			end
			S_GCD_DIV: begin
				div_rem_q <= div_rem_nx;
				div_quo_q <= div_quo_nx;
				if (last) begin
					a_q <= b_q;
					b_q <= div_rem_nx;
				end
			end
			S_QDIV: begin
				div_rem_q <= div_rem_nx;
				div_quo_q <= div_quo_nx;
				if (last) begin
					q_q          <= div_quo_nx;
					mul_acc_q    <= '0;
					mul_mcand_q  <= {2'b00, p_q - W'(1)};
					mul_mplier_q <= div_quo_nx - W'(1);
				end
			end
			S_PHI_MUL: begin
				mul_acc_q    <= mul_acc_nx;
				mul_mcand_q  <= {mul_mcand_q[MW-2:0], 1'b0};
				mul_mplier_q <= {1'b0, mul_mplier_q[W-1:1]};
				if (last) begin
					phi_q <= mul_acc_nx[W-1:0];
					r_q   <= mul_acc_nx[W-1:0];
					nr_q  <= e_q;
					t_q   <= '0;
					nt_q  <= MW'(1);
				end
			end
			S_EXT_CHK: begin
				div_rem_q <= '0;
				div_quo_q <= r_q;
				div_den_q <= nr_q;
				if (nr_q == '0) begin
					if (r_q > W'(1)) begin
						status_q <= ST_NOT_INV;
						d_q      <= '0;
					end else if (t_q[MW-1]) begin
						t_q <= t_q + phi_ext;
					end
				end
			end
			S_EXT_DIV: begin
				div_rem_q <= div_rem_nx;
				div_quo_q <= div_quo_nx;
				if (last) begin
					r_q          <= nr_q;
					nr_q         <= div_rem_nx;
					mul_acc_q    <= '0;
					mul_mcand_q  <= nt_q;
					mul_mplier_q <= div_quo_nx;
				end
			end
			S_EXT_MUL: begin
				mul_acc_q    <= mul_acc_nx;
				mul_mcand_q  <= {mul_mcand_q[MW-2:0], 1'b0};
				mul_mplier_q <= {1'b0, mul_mplier_q[W-1:1]};
				if (last) begin
					t_q  <= nt_q;
					nt_q <= t_q - mul_acc_nx;
				end
			end
			S_FIN: begin
				// t is in 0..phi here, one subtract folds it below phi
				status_q <= ST_FOUND;
				d_q      <= (t_q >= phi_ext) ? W'(t_q - phi_ext) : t_q[W-1:0];
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	`RKR_ASSERT(a_ready_vs_valid, clk, arst_n, !(in_ready && out_valid))
	`RKR_ASSERT_IMPL(a_div_den_nonzero, clk, arst_n,
		(state_q == S_GCD_DIV || state_q == S_QDIV || state_q == S_EXT_DIV),
		div_den_q != '0)
	`RKR_ASSERT_IMPL(a_no_factor_zeros, clk, arst_n,
		out_valid && status_q == ST_NO_FACTOR, q_q == '0 && d_q == '0)
	`RKR_ASSERT_IMPL(a_d_below_phi, clk, arst_n,
		out_valid && status_q == ST_FOUND, d_q < phi_q)

endmodule

FILE: tb/sv/rsa_key_recovery_common_factor_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_key_recovery_common_factor_unit_tb
// checks p, q, d and status for each beat against an in-bench key recovery
// predictor: directed corner cases, random factorable keys, random noise,
// random stalls on both channels and a final stretch at full rate
// ----------------------------------------------------------------------------
module rsa_key_recovery_common_factor_unit_tb;
	import rkr_pkg::*;

	localparam int DW = 63;
	localparam int CYCLE_LIMIT = 20000000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		status_t       status;
		bit [DW-1:0]   p;
		bit [DW-1:0]   q;
		bit [DW-1:0]   d;
	} key_result_t;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	logic [DW-1:0] modulus;
	logic [DW-1:0] public_exponent;
	logic [DW-1:0] known_block;
	logic          out_valid;
	logic          out_ready;
	logic [1:0]    status;
	logic [DW-1:0] factor_p;
	logic [DW-1:0] factor_q;
	logic [DW-1:0] private_exponent;

	key_result_t expected_keys[$];
	int          errors;
	int          cycles;
	bit          quiet;

	rsa_key_recovery_common_factor_unit #(.DATA_WIDTH(DW)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.modulus(modulus),
		.public_exponent(public_exponent),
		.known_block(known_block),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.factor_p(factor_p),
		.factor_q(factor_q),
		.private_exponent(private_exponent)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit [63:0] gcd64(bit [63:0] a, bit [63:0] b);
		bit [63:0] r;
		while (b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	// coefficients wrap mod 2^64; true magnitude stays below phi
	function automatic key_result_t recover_key(bit [DW-1:0] n, bit [DW-1:0] e,
			bit [DW-1:0] m);
		key_result_t res;
		bit [63:0] g, qv, phi, t, nt, r, nr, qt, tmp;
		g = gcd64({1'b0, m}, {1'b0, n});
		res.status = ST_NO_FACTOR;
		res.p = g[DW-1:0];
		res.q = '0;
		res.d = '0;
		if (n == 0 || g <= 1 || g == {1'b0, n})
			return res;
		qv = {1'b0, n} / g;
		phi = (g - 1) * (qv - 1);
		res.q = qv[DW-1:0];
		t = 0;
		nt = 1;
		r = phi;
		nr = {1'b0, e};
		while (nr != 0) begin
			qt = r / nr;
			tmp = t;
			t = nt;
			nt = tmp - qt * nt;
			tmp = r;
			r = nr;
			nr = tmp - qt * nr;
		end
		if (r > 1) begin
			res.status = ST_NOT_INV;
			return res;
		end
		if (t[63])
			t = t + phi;
		t = t % phi;
		res.status = ST_FOUND;
		res.d = t[DW-1:0];
		return res;
	endfunction

	function automatic bit [DW-1:0] rand_word();
		bit [63:0] v;
		v = {$urandom, $urandom};
		return v[DW-1:0];
	endfunction

	task automatic report_mismatch(string field, bit [DW-1:0] got, bit [DW-1:0] want);
		$display("mismatch on %s: got %0d expected %0d at cycle %0d", field, got, want,
			cycles);
		errors++;
	endtask

	// valid stays high between back-to-back beats
	task automatic send_key(bit [DW-1:0] n, bit [DW-1:0] e, bit [DW-1:0] m);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		modulus <= n;
		public_exponent <= e;
		known_block <= m;
		do @(posedge clk); while (!in_ready);
		expected_keys.push_back(recover_key(n, e, m));
	endtask

	task automatic random_factorable_key();
		bit [63:0] p, q, n, k, e;
		p = 64'($urandom >> $urandom_range(1, 30));
		q = 64'($urandom >> $urandom_range(1, 30));
		if (p < 2) p = 2;
		if (q < 2) q = 2;
		n = p * q;
		k = 1 + ({$urandom, $urandom} % (64'h7fff_ffff_ffff_ffff / p));
		case ($urandom_range(0, 3))
			0: e = 65537;
			1: e = 3;
			2: e = {$urandom, $urandom} | 1;
			default: e = 64'($urandom_range(0, 1000));
		endcase
		send_key(n[DW-1:0], e[DW-1:0], (p * k) & {1'b0, {DW{1'b1}}});
	endtask

	task automatic test_corner_cases();
		bit [DW-1:0] ones;
		ones = '1;
		send_key(0, 65537, 12345);
		send_key(0, 0, 0);
		send_key(143, 7, 0);
		send_key(143, 7, 1);
		send_key(143, 7, 143);
		send_key(143, 7, 11);
		send_key(143, 7, 26);
		send_key(143, 0, 13);
		send_key(143, 1000001, 11);
		send_key(143, 6, 11);
		send_key(4, 5, 2);
		send_key(4, 0, 6);
		send_key(ones, ones, ones);
		send_key(ones, ones, 7);
		send_key(ones, 0, 0);
		send_key(ones, ones, 49);
		send_key(63'h4000_0000_0000_0000, 3, 63'h2000_0000_0000_0000);
		send_key(63'd4611686014132420609, 65537, 63'd2147483647);
	endtask

	task automatic test_random_keys(int count);
		repeat (count) random_factorable_key();
	endtask

	task automatic test_random_noise(int count);
		repeat (count) send_key(rand_word(), rand_word(), rand_word());
	endtask

	task automatic test_full_rate(int count);
		quiet = 1'b1;
		repeat (count) begin
			if ($urandom_range(0, 3) == 0)
				send_key(rand_word(), rand_word(), rand_word());
			else
				random_factorable_key();
		end
	endtask

	initial begin
		int i;
		errors = 0;
		quiet = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		modulus <= '0;
		public_exponent <= '0;
		known_block <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_cases();
		test_random_keys(60);
		test_random_noise(15);
		test_full_rate(12);
		in_valid <= 1'b0;
		while (expected_keys.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		out_ready <= 1'b0;
		forever begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// result beat check
	always @(posedge clk) begin
		key_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_keys.size() == 0) begin
				$display("unexpected result beat at cycle %0d", cycles);
				errors++;
			end else begin
				want = expected_keys.pop_front();
				if (status !== want.status)
					report_mismatch("status", DW'(status), DW'(want.status));
				if (factor_p !== want.p)
					report_mismatch("factor_p", factor_p, want.p);
				if (factor_q !== want.q)
					report_mismatch("factor_q", factor_q, want.q);
				if (private_exponent !== want.d)
					report_mismatch("private_exponent", private_exponent, want.d);
			end
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

endmodule
